### rtl/nmp_pkg.sv
// ----------------------------------------------------------------------------
// nmp_pkg
// Shared types and constants of the NoC message packetizer: the command word
// passed from the front end to the flit generator, and register indexes.
// ----------------------------------------------------------------------------
package nmp_pkg;

    // Default packet length in flits, header flits per packet
    localparam int PACKET_FLITS_DEF = 64;
    localparam int HEADER_FLITS     = 8;

    // Default depth of the command queue between front end and back end
    localparam int CMDQ_DEPTH_DEF = 4;

    // Filler flit for the tail of the last packet
    localparam logic [15:0] PAD_FLIT  = 16'hdead;
    localparam logic [15:0] ZERO_FLIT = 16'h0000;

    // Configuration register indexes
    localparam logic REG_LOCAL_CORE     = 1'b0;
    localparam logic REG_RECEIVER_SLOTS = 1'b1;

    // Header flit slots within a packet
    localparam logic [2:0] HDR_DEST_CORE = 3'd0;
    localparam logic [2:0] HDR_LENGTH    = 3'd1;
    localparam logic [2:0] HDR_SRC_CORE  = 3'd2;
    localparam logic [2:0] HDR_TASKS     = 3'd3;
    localparam logic [2:0] HDR_SIZE      = 3'd4;
    localparam logic [2:0] HDR_SEQ       = 3'd5;
    localparam logic [2:0] HDR_LAST      = 3'd7;

    // Kind of work the back end carries out for one input word
    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,   // optional headers, one data flit, optional padding
        CMD_EMPTY  = 2'd1,   // headers and padding only (zero-size message)
        CMD_REJECT = 2'd2    // single reject result
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        need_hdr;   // packet starts with this word
        logic        last;       // word ends the message
        logic [15:0] dest_core;
        logic [15:0] task_pair;
        logic [15:0] size_bytes;
        logic [15:0] seq_num;
        logic [15:0] data;
    } cmd_t;

endpackage

### rtl/nmp_front.sv
// ----------------------------------------------------------------------------
// nmp_front
// Front end: accepts message words, tracks message and packet position, checks
// feasibility and turns each word it does not drop into one back-end command.
// ----------------------------------------------------------------------------
module nmp_front
    import nmp_pkg::*;
#(
    parameter int PACKET_FLITS = PACKET_FLITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] dest_core,
    input  logic [7:0]  dest_task,
    input  logic [7:0]  src_task,
    input  logic [15:0] message_bytes,
    input  logic [15:0] data_word,
    input  logic        final_word,
    input  logic [7:0]  receiver_slots,
    input  logic        cmd_full,
    output logic        cmd_push,
    output cmd_t        cmd
);

    localparam int POS_W      = $clog2(PACKET_FLITS);
    localparam int PER_PACKET = 2 * (PACKET_FLITS - HEADER_FLITS);

    logic              in_message_reg, in_message_next;
    logic              discarding_reg, discarding_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       seq_reg, seq_next;
    logic [15:0]       dest_reg, dest_next;
    logic [15:0]       pair_reg, pair_next;
    logic [15:0]       size_reg, size_next;

    logic              accept;
    logic [23:0]       size_limit;
    logic              infeasible;
    logic [15:0]       bl_base;
    logic [15:0]       bl_used;
    logic [POS_W-1:0]  pos_base;
    logic [15:0]       seq_base;
    logic [POS_W:0]    pos_sum;
    logic              need_hdr;
    logic              msg_end;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && !cmd_full;

    // Reject when size / per_packet + 1 exceeds the slots
    assign size_limit = 24'(receiver_slots) * 24'(PER_PACKET);
    assign infeasible = {8'd0, message_bytes} >= size_limit;

    // First word of a message starts from its own descriptors
    assign bl_base  = (in_message_reg || discarding_reg) ? bytes_left_reg : message_bytes;
    assign pos_base = in_message_reg ? pos_reg : '0;
    assign seq_base = in_message_reg ? seq_reg : 16'd0;
    assign bl_used  = (bl_base >= 16'd2) ? (bl_base - 16'd2) : 16'd0;
    assign msg_end  = final_word || (bl_used == 16'd0);
    assign need_hdr = (pos_base == '0);
    assign pos_sum  = {1'b0, pos_base}
                    + (need_hdr ? (POS_W+1)'(HEADER_FLITS + 1) : (POS_W+1)'(1));

    // Classify the word and build its command
    always_comb
    begin
        in_message_next = in_message_reg;
        discarding_next = discarding_reg;
        bytes_left_next = bytes_left_reg;
        pos_next        = pos_reg;
        seq_next        = seq_reg;
        dest_next       = dest_reg;
        pair_next       = pair_reg;
        size_next       = size_reg;
        cmd_push        = 1'b0;
        cmd.kind        = CMD_DATA;
        cmd.need_hdr    = need_hdr;
        cmd.last        = msg_end;
        cmd.dest_core   = in_message_reg ? dest_reg : dest_core;
        cmd.task_pair   = in_message_reg ? pair_reg : {src_task, dest_task};
        cmd.size_bytes  = in_message_reg ? size_reg : message_bytes;
        cmd.seq_num     = need_hdr ? (seq_base + 16'd1) : seq_base;
        cmd.data        = data_word;

        if (accept)
        begin
            if (discarding_reg)
            begin
                // Drop words of a rejected message
                bytes_left_next = bl_used;
                if (msg_end)
                begin
                    discarding_next = 1'b0;
                end
            end
            else if (!in_message_reg && infeasible)
            begin
                cmd_push        = 1'b1;
                cmd.kind        = CMD_REJECT;
                bytes_left_next = bl_used;
                discarding_next = !msg_end;
                pos_next        = '0;
            end
            else if (!in_message_reg && (message_bytes == 16'd0))
            begin
                cmd_push     = 1'b1;
                cmd.kind     = CMD_EMPTY;
                cmd.need_hdr = 1'b1;
                cmd.last     = 1'b1;
                cmd.seq_num  = 16'd1;
                pos_next     = '0;
            end
            else
            begin
                // Data word, first of a message or a later one
                cmd_push        = 1'b1;
                dest_next       = cmd.dest_core;
                pair_next       = cmd.task_pair;
                size_next       = cmd.size_bytes;
                seq_next        = cmd.seq_num;
                bytes_left_next = bl_used;
                in_message_next = !msg_end;
                if (msg_end || (pos_sum == (POS_W+1)'(PACKET_FLITS)))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_sum[POS_W-1:0];
                end
            end
        end
    end

    // Hold message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
            discarding_reg <= 1'b0;
            bytes_left_reg <= '0;
            pos_reg        <= '0;
            seq_reg        <= '0;
        end
        else
        begin
            in_message_reg <= in_message_next;
            discarding_reg <= discarding_next;
            bytes_left_reg <= bytes_left_next;
            pos_reg        <= pos_next;
            seq_reg        <= seq_next;
        end
    end

    // Hold sampled descriptors
    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        pair_reg <= pair_next;
        size_reg <= size_next;
    end

endmodule

### rtl/nmp_cmdq.sv
// ----------------------------------------------------------------------------
// nmp_cmdq
// Command queue: a short FIFO that decouples the front end from the flit
// generator, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module nmp_cmdq
    import nmp_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/nmp_back.sv
// ----------------------------------------------------------------------------
// nmp_back
// Flit generator: expands the queue head command into header, data, padding
// or reject flits, one per cycle unless stalled, to a registered output stage.
// ----------------------------------------------------------------------------
module nmp_back
    import nmp_pkg::*;
#(
    parameter int PACKET_FLITS = PACKET_FLITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] local_core,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] flit,
    output logic        packet_done,
    output logic        message_done,
    output logic        outcome
);

    localparam int POS_W = $clog2(PACKET_FLITS);

    typedef enum logic [3:0] {
        PH_FIRST = 4'b0001,
        PH_HDR   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_PAD   = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [2:0]       hdr_idx_reg, hdr_idx_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg;
    logic [15:0]      flit_reg;
    logic             pd_reg, md_reg, oc_reg;

    logic             can_load;
    logic             emit;
    logic             wrap;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      gen_flit;
    logic             gen_pd, gen_md, gen_oc;
    logic             cmd_done;

    // Select header flit by slot
    function automatic logic [15:0] header_flit(input logic [2:0] idx, input cmd_t c,
                                                input logic [15:0] src_core);
        logic [15:0] f;
        case (idx)
            HDR_DEST_CORE: f = c.dest_core;
            HDR_LENGTH:    f = 16'(PACKET_FLITS - 2);
            HDR_SRC_CORE:  f = src_core;
            HDR_TASKS:     f = c.task_pair;
            HDR_SIZE:      f = c.size_bytes;
            HDR_SEQ:       f = c.seq_num;
            default:       f = ZERO_FLIT;
        endcase
        return f;
    endfunction

    assign can_load = !out_valid_reg || out_ready;
    assign emit     = can_load && head_valid;
    assign wrap     = (pos_reg == POS_W'(PACKET_FLITS - 1));
    assign pos_inc  = wrap ? '0 : pos_reg + 1'b1;
    assign pop      = emit && cmd_done;

    // Produce the next flit of the head command
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        pos_next     = pos_inc;
        gen_flit     = head_cmd.data;
        gen_pd       = wrap;
        gen_md       = 1'b0;
        gen_oc       = 1'b0;
        cmd_done     = 1'b0;
        case (phase_reg)
            PH_FIRST:
            begin
                if (head_cmd.kind == CMD_REJECT)
                begin
                    gen_flit = ZERO_FLIT;
                    gen_pd   = 1'b0;
                    gen_md   = head_cmd.last;
                    gen_oc   = 1'b1;
                    pos_next = pos_reg;
                    cmd_done = 1'b1;
                end
                else if (head_cmd.need_hdr)
                begin
                    gen_flit     = header_flit(HDR_DEST_CORE, head_cmd, local_core);
                    hdr_idx_next = HDR_DEST_CORE + 3'd1;
                    phase_next   = PH_HDR;
                end
                else if (head_cmd.last && !wrap)
                begin
                    phase_next = PH_PAD;
                end
                else
                begin
                    gen_md   = head_cmd.last;
                    cmd_done = 1'b1;
                end
            end
            PH_HDR:
            begin
                gen_flit     = header_flit(hdr_idx_reg, head_cmd, local_core);
                hdr_idx_next = hdr_idx_reg + 3'd1;
                if (hdr_idx_reg == HDR_LAST)
                begin
                    phase_next = (head_cmd.kind == CMD_EMPTY) ? PH_PAD : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (head_cmd.last && !wrap)
                begin
                    phase_next = PH_PAD;
                end
                else
                begin
                    gen_md     = head_cmd.last;
                    cmd_done   = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            PH_PAD:
            begin
                gen_flit = PAD_FLIT;
                if (wrap)
                begin
                    gen_md     = 1'b1;
                    cmd_done   = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
                pos_next   = pos_reg;
            end
        endcase
    end

    // Advance generator state on each emitted flit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            hdr_idx_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                phase_reg   <= phase_next;
                hdr_idx_reg <= hdr_idx_next;
                pos_reg     <= pos_next;
            end
            if (can_load)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    // Load output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            flit_reg <= gen_flit;
            pd_reg   <= gen_pd;
            md_reg   <= gen_md;
            oc_reg   <= gen_oc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign flit         = flit_reg;
    assign packet_done  = pd_reg;
    assign message_done = md_reg;
    assign outcome      = oc_reg;

endmodule

### rtl/noc_message_packetizer.sv
// ----------------------------------------------------------------------------
// noc_message_packetizer
// Splits messages into fixed-size 16-bit NoC packets with header flits.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries message words: descriptors in s_tdata are sampled on the
//   first word of a message, s_tlast marks its last word. m_* carries flits
//   toward the network; m_tlast marks the last flit of a packet, m_tuser
//   flags the end of a message and a rejected message.
//   cfg_we/cfg_index/cfg_data write local_core (0) and receiver_slots (1);
//   write them only while no message is in flight.
// Timing:
//   A word is accepted when the command queue has room. Its first result
//   passes through the command queue and the output register to m_*. The flit
//   generator issues one flit per cycle while m_tready allows, so a word yields
//   1 flit, 9 flits when it opens a packet, and up to PACKET_FLITS at message end
//   with padding. Output bandwidth of the generator sets the sustained rate;
//   the CMDQ_DEPTH-entry queue absorbs header and padding bursts.
// Reset: all message state clears, no message is open, local_core = 0,
//   receiver_slots = 8. A stalled m_tready holds the output flit; the queue
//   then fills and s_tready drops.
// ----------------------------------------------------------------------------
module noc_message_packetizer
    import nmp_pkg::*;
#(
    parameter int PACKET_FLITS = PACKET_FLITS_DEF,
    parameter int CMDQ_DEPTH   = CMDQ_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // dest_core, dest_task, src_task, message_bytes, data_word
    input  logic        s_tlast,    // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // flit
    output logic        m_tlast,    // packet_done
    output logic [1:0]  m_tuser,    // message_done, outcome
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] local_core_reg;
    logic [7:0]  slots_reg;

    logic        cmd_push;
    logic        cmd_full;
    cmd_t        cmd;
    logic        head_valid;
    cmd_t        head_cmd;
    logic        head_pop;
    logic        msg_done;
    logic        reject;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_core_reg <= 16'd0;
            slots_reg      <= 8'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCAL_CORE:     local_core_reg <= cfg_data;
                REG_RECEIVER_SLOTS: slots_reg      <= cfg_data[7:0];
                default:            local_core_reg <= local_core_reg;
            endcase
        end
    end

    nmp_front #(
        .PACKET_FLITS   (PACKET_FLITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .dest_core      (s_tdata[15:0]),
        .dest_task      (s_tdata[23:16]),
        .src_task       (s_tdata[31:24]),
        .message_bytes  (s_tdata[47:32]),
        .data_word      (s_tdata[63:48]),
        .final_word     (s_tlast),
        .receiver_slots (slots_reg),
        .cmd_full       (cmd_full),
        .cmd_push       (cmd_push),
        .cmd            (cmd)
    );

    nmp_cmdq #(
        .DEPTH          (CMDQ_DEPTH)
    ) u_cmdq (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (cmd_push),
        .push_cmd       (cmd),
        .full           (cmd_full),
        .pop            (head_pop),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd)
    );

    nmp_back #(
        .PACKET_FLITS   (PACKET_FLITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .local_core     (local_core_reg),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (head_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .flit           (m_tdata),
        .packet_done    (m_tlast),
        .message_done   (msg_done),
        .outcome        (reject)
    );

    assign m_tuser = {reject, msg_done};

endmodule

### tb/sv/noc_message_packetizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noc_message_packetizer_tb
// Drives message words into the packetizer and checks every flit against an
// in-bench packet builder. The tests cover field extremes, zero-size, odd-size,
// early-ended and rejected messages, and register extremes. Random traffic
// follows, with idle bursts on both sides, a long output hold-off and drain
// pauses.
// ----------------------------------------------------------------------------
module noc_message_packetizer_tb;
    import nmp_pkg::*;

    localparam int PACKET_FLITS     = PACKET_FLITS_DEF;
    localparam int BYTES_PER_PACKET = 2 * PACKET_FLITS - 2 * HEADER_FLITS;
    localparam int SETTLE_CYCLES    = 16;
    localparam int HOLDOFF_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PHASES    = 4;
    localparam int PHASE_WORDS      = 60;
    localparam int MAX_PRINTED      = 50;

    // m_tuser bit positions and outcome codes
    localparam int   TUSER_MSG_DONE = 0;
    localparam int   TUSER_OUTCOME  = 1;
    localparam logic OUTCOME_FLIT   = 1'b0;
    localparam logic OUTCOME_REJECT = 1'b1;

    typedef struct packed {
        logic [15:0] dest_core;
        logic [7:0]  dest_task;
        logic [7:0]  src_task;
        logic [15:0] message_bytes;
        logic [15:0] data_word;
        logic        final_word;
    } msg_word_t;

    typedef struct packed {
        logic [15:0] flit;
        logic        packet_done;
        logic        message_done;
        logic        rejected;
    } flit_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // dest_core, dest_task, src_task, message_bytes, data_word
    logic        s_tlast;    // final_word
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // flit
    logic        m_tlast;    // packet_done
    logic [1:0]  m_tuser;    // message_done, outcome
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    noc_message_packetizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Packet builder state, mirrors the block after reset
    logic [15:0] cfg_local_core     = 16'h0000;
    logic [7:0]  cfg_receiver_slots = 8'd8;
    int          flit_pos           = 0;
    logic [15:0] packet_seq         = 16'h0000;
    logic [15:0] bytes_left         = 16'h0000;
    logic [15:0] hdr_dest_core      = 16'h0000;
    logic [15:0] hdr_task_pair      = 16'h0000;
    logic [15:0] hdr_size           = 16'h0000;
    bit          in_message         = 1'b0;
    bit          discarding         = 1'b0;

    flit_result_t expected_flits[$];
    int           mismatch_count  = 0;
    int           results_seen    = 0;
    int           words_sent      = 0;
    int           stall_cycles    = 0;
    bit           steady_traffic  = 1'b0;
    bit           holdoff_request = 1'b0;

    // ------------------------------------------------------------------------
    // Packet builder
    // ------------------------------------------------------------------------

    function automatic void emit_flit(input logic [15:0] value);
        flit_result_t r;
        r.flit         = value;
        r.packet_done  = 1'b0;
        r.message_done = 1'b0;
        r.rejected     = OUTCOME_FLIT;
        flit_pos++;
        if (flit_pos >= PACKET_FLITS)
        begin
            r.packet_done = 1'b1;
            flit_pos      = 0;
        end
        expected_flits.push_back(r);
    endfunction

    function automatic void emit_headers();
        packet_seq = packet_seq + 16'd1;
        emit_flit(hdr_dest_core);
        emit_flit(16'(PACKET_FLITS - 2));
        emit_flit(cfg_local_core);
        emit_flit(hdr_task_pair);
        emit_flit(hdr_size);
        emit_flit(packet_seq);
        emit_flit(ZERO_FLIT);
        emit_flit(ZERO_FLIT);
    endfunction

    // Pad out the open packet and flag the last flit as message end
    function automatic void close_message();
        flit_result_t r;
        while (flit_pos != 0)
            emit_flit(PAD_FLIT);
        in_message     = 1'b0;
        r              = expected_flits.pop_back();
        r.message_done = 1'b1;
        expected_flits.push_back(r);
    endfunction

    function automatic void consume_word_bytes();
        bytes_left = (bytes_left >= 16'd2) ? bytes_left - 16'd2 : 16'd0;
    endfunction

    function automatic void predict_word(input msg_word_t w);
        flit_result_t r;
        bit           ends;
        // swallow the rest of a rejected message
        if (discarding)
        begin
            consume_word_bytes();
            if (w.final_word || bytes_left == 16'd0)
                discarding = 1'b0;
            return;
        end
        if (!in_message)
        begin
            hdr_dest_core = w.dest_core;
            hdr_task_pair = {w.src_task, w.dest_task};
            hdr_size      = w.message_bytes;
            bytes_left    = w.message_bytes;
            packet_seq    = 16'h0000;
            flit_pos      = 0;
            if (int'(w.message_bytes) / BYTES_PER_PACKET + 1 > int'(cfg_receiver_slots))
            begin
                consume_word_bytes();
                ends           = w.final_word || bytes_left == 16'd0;
                discarding     = !ends;
                r.flit         = ZERO_FLIT;
                r.packet_done  = 1'b0;
                r.message_done = ends;
                r.rejected     = OUTCOME_REJECT;
                expected_flits.push_back(r);
                return;
            end
            in_message = 1'b1;
            if (w.message_bytes == 16'd0)
            begin
                emit_headers();
                close_message();
                return;
            end
        end
        if (flit_pos == 0)
            emit_headers();
        consume_word_bytes();
        ends = w.final_word || bytes_left == 16'd0;
        emit_flit(w.data_word);
        if (ends)
            close_message();
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and watchdog, sampled mid-cycle
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(negedge clk)
    begin
        flit_result_t got;
        flit_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata, m_tlast, m_tuser[TUSER_MSG_DONE], m_tuser[TUSER_OUTCOME]};
                if (expected_flits.size() == 0)
                    report_mismatch($sformatf("result %0d: unexpected flit %h",
                                              results_seen, got.flit));
                else
                begin
                    want = expected_flits.pop_front();
                    if (got.flit !== want.flit)
                        report_mismatch($sformatf("result %0d: flit %h, expected %h",
                                                  results_seen, got.flit, want.flit));
                    if (got.packet_done !== want.packet_done)
                        report_mismatch($sformatf("result %0d: packet_done %b, expected %b",
                                                  results_seen, got.packet_done,
                                                  want.packet_done));
                    if (got.message_done !== want.message_done)
                        report_mismatch($sformatf("result %0d: message_done %b, expected %b",
                                                  results_seen, got.message_done,
                                                  want.message_done));
                    if (got.rejected !== want.rejected)
                        report_mismatch($sformatf("result %0d: outcome %b, expected %b",
                                                  results_seen, got.rejected, want.rejected));
                end
                results_seen++;
            end
            // count cycles in which neither side moves a word
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[%0t] watchdog: no progress for %0d cycles",
                             $realtime, WATCHDOG_LIMIT);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts, long hold-off on request
    // ------------------------------------------------------------------------

    initial
    begin
        int   holdoff_left;
        int   burst_left;
        logic burst_ready;
        logic next_ready;
        holdoff_left = 0;
        burst_left   = 0;
        burst_ready  = 1'b1;
        m_tready     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                next_ready = 1'b0;
            end
            else if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                holdoff_left    = HOLDOFF_CYCLES - 1;
                next_ready      = 1'b0;
            end
            else if (steady_traffic)
                next_ready = 1'b1;
            else if (burst_left > 0)
            begin
                burst_left--;
                next_ready = burst_ready;
            end
            else
            begin
                burst_ready = ($urandom_range(0, 2) != 0);
                burst_left  = $urandom_range(1, 12) - 1;
                next_ready  = burst_ready;
            end
            m_tready <= rst_n ? next_ready : 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    function automatic msg_word_t make_word(input logic [15:0] dest_core,
                                            input logic [7:0]  dest_task,
                                            input logic [7:0]  src_task,
                                            input logic [15:0] message_bytes,
                                            input logic [15:0] data_word,
                                            input logic        final_word);
        msg_word_t w;
        w.dest_core     = dest_core;
        w.dest_task     = dest_task;
        w.src_task      = src_task;
        w.message_bytes = message_bytes;
        w.data_word     = data_word;
        w.final_word    = final_word;
        return w;
    endfunction

    function automatic msg_word_t random_word();
        return make_word(16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 8'hff)),
                         8'($urandom_range(0, 8'hff)), 16'($urandom_range(0, 16'hffff)),
                         16'($urandom_range(0, 16'hffff)), 1'b0);
    endfunction

    // Offer one word, hold it until taken, then update the expected flits
    task automatic send_word(input msg_word_t w);
        s_tdata  <= {w.data_word, w.message_bytes, w.src_task, w.dest_task, w.dest_core};
        s_tlast  <= w.final_word;
        s_tvalid <= 1'b1;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        predict_word(w);
        words_sent++;
    endtask

    task automatic sender_gap();
        if (!steady_traffic && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // First word carries the size, later words carry random ignored descriptors
    task automatic send_message(input logic [15:0] bytes, input int n_words,
                                input bit mark_last);
        msg_word_t w;
        for (int i = 0; i < n_words; i++)
        begin
            w = random_word();
            if (i == 0)
                w.message_bytes = bytes;
            w.final_word = mark_last && (i == n_words - 1);
            send_word(w);
            sender_gap();
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_flits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_LOCAL_CORE)
            cfg_local_core = value;
        else
            cfg_receiver_slots = value[7:0];
    endtask

    task automatic set_config(input logic [15:0] core, input logic [7:0] slots);
        write_register(REG_LOCAL_CORE, core);
        write_register(REG_RECEIVER_SLOTS, {8'h00, slots});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: field extremes and each message corner
    task automatic test_directed_cases();
        // two-word message; the second word's descriptors must be ignored
        send_word(make_word(16'hffff, 8'hff, 8'h00, 16'd4, 16'hffff, 1'b0));
        send_word(make_word(16'h0000, 8'h00, 8'hff, 16'hffff, 16'h0000, 1'b1));
        // odd byte count, ends on byte count with no final word
        send_word(make_word(16'h0000, 8'h00, 8'hff, 16'd5, 16'h1234, 1'b0));
        send_word(make_word(16'h1234, 8'h5a, 8'ha5, 16'd0, 16'h5678, 1'b0));
        send_word(make_word(16'hfedc, 8'h11, 8'h22, 16'd7, 16'hbcde, 1'b0));
        // early final word pads the packet
        send_word(make_word(16'h8001, 8'h80, 8'h01, 16'd40, 16'h8000, 1'b0));
        send_word(make_word(16'h0000, 8'h00, 8'h00, 16'd0, 16'h0001, 1'b1));
        // zero-size messages, with and without final word
        send_word(make_word(16'h00ff, 8'h0f, 8'hf0, 16'd0, 16'habcd, 1'b0));
        send_word(make_word(16'hff00, 8'hf0, 8'h0f, 16'd0, 16'h4321, 1'b1));
        // rejected message, further words dropped up to the final word
        send_word(make_word(16'h7777, 8'h77, 8'h77, 16'hffff, 16'hffff, 1'b0));
        send_word(make_word(16'h0000, 8'h00, 8'h00, 16'd2, 16'h1111, 1'b0));
        send_word(make_word(16'h0000, 8'h00, 8'h00, 16'd2, 16'h2222, 1'b1));
        // rejected on a single word, just above the slot limit
        send_word(make_word(16'h2468, 8'h24, 8'h68, 16'(8 * BYTES_PER_PACKET),
                            16'h3333, 1'b1));
        // one more word after the reject opens a fresh message
        send_word(make_word(16'h1357, 8'h13, 8'h57, 16'd1, 16'h9abc, 1'b0));
        wait_for_drain();
    endtask

    // Register extremes and the feasibility boundary at each
    task automatic test_config_extremes();
        set_config(16'hffff, 8'd1);
        send_word(make_word(16'h0101, 8'h01, 8'h02, 16'(BYTES_PER_PACKET - 1), 16'haaaa, 1'b0));
        send_word(make_word(16'h0202, 8'h03, 8'h04, 16'd0, 16'h5555, 1'b1));
        send_word(make_word(16'h0303, 8'h05, 8'h06, 16'(BYTES_PER_PACKET), 16'hcccc, 1'b1));
        send_word(make_word(16'h0404, 8'h07, 8'h08, 16'd0, 16'h3333, 1'b0));
        wait_for_drain();
        set_config(16'h0000, 8'd255);
        send_word(make_word(16'h0505, 8'h09, 8'h0a, 16'(255 * BYTES_PER_PACKET - 1),
                            16'h0f0f, 1'b0));
        send_word(make_word(16'h0606, 8'h0b, 8'h0c, 16'd0, 16'hf0f0, 1'b1));
        send_word(make_word(16'h0707, 8'h0d, 8'h0e, 16'(255 * BYTES_PER_PACKET),
                            16'h7f7f, 1'b1));
        wait_for_drain();
    endtask

    // Receiver stalls long while words keep coming, so the input backs up
    task automatic test_output_holdoff();
        set_config(16'($urandom_range(0, 16'hffff)), 8'd8);
        holdoff_request = 1'b1;
        send_message(16'd80, 40, 1'b1);
        wait_for_drain();
    endtask

    // Sender waits for every flit before the next message
    task automatic test_pause_for_drain();
        repeat (3)
        begin
            send_message(16'($urandom_range(1, 60)), 1 + $urandom_range(0, 29), 1'b1);
            wait_for_drain();
        end
    endtask

    task automatic send_random_message();
        int        max_ok;
        int        cap;
        int        bytes;
        int        pick;
        int        boundary[8];
        msg_word_t w;
        boundary = '{1, 2, 111, 112, 113, 223, 224, 225};
        max_ok   = int'(cfg_receiver_slots) * BYTES_PER_PACKET - 1;
        cap      = (max_ok < 160) ? max_ok : 160;
        pick     = $urandom_range(0, 99);
        if (pick < 60)
        begin
            // well-formed, ends on byte count with or without final word
            if ($urandom_range(0, 7) == 0)
                bytes = boundary[$urandom_range(0, 7)];
            else
                bytes = $urandom_range(1, cap);
            if (bytes > max_ok)
                bytes = max_ok;
            send_message(16'(bytes), (bytes + 1) / 2, 1'($urandom_range(0, 1)));
        end
        else if (pick < 72)
        begin
            // final word before the byte count runs out
            bytes = $urandom_range(3, cap);
            send_message(16'(bytes), $urandom_range(1, (bytes + 1) / 2 - 1), 1'b1);
        end
        else if (pick < 82)
            send_message(16'd0, 1, 1'($urandom_range(0, 1)));
        else if (pick < 95)
        begin
            if ($urandom_range(0, 3) == 0)
                bytes = max_ok + 1;
            else
                bytes = $urandom_range(max_ok + 1, 16'hffff);
            send_message(16'(bytes), $urandom_range(1, 4), 1'b1);
        end
        else
        begin
            // stray word with random descriptors
            w            = random_word();
            w.final_word = 1'($urandom_range(0, 1));
            send_word(w);
            sender_gap();
        end
    endtask

    // Random messages over several register settings; last phase runs flat out
    task automatic test_random_traffic();
        int          start_words;
        logic [7:0]  slots;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       slots = 8'd1;
                1:       slots = 8'd255;
                2:       slots = 8'($urandom_range(2, 254));
                default: slots = 8'd8;
            endcase
            set_config(16'($urandom_range(0, 16'hffff)), slots);
            steady_traffic = (phase == RANDOM_PHASES - 1);
            start_words    = words_sent;
            while (words_sent - start_words < PHASE_WORDS)
                send_random_message();
            // close any open or discarded message before the next write
            send_word(make_word(16'($urandom_range(0, 16'hffff)), 8'h00, 8'h00, 16'd2,
                                16'($urandom_range(0, 16'hffff)), 1'b1));
            wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 64'h0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LOCAL_CORE;
        cfg_data  = 16'h0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_config_extremes();
        test_output_holdoff();
        test_pause_for_drain();
        test_random_traffic();

        wait_for_drain();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
